// ===== hw/rtl/ucal_pkg.sv =====
// ----------------------------------------------------------------------------
// Unix seconds to calendar: shared package
// Stage count, stage enable type, day-count constants and the fixed-point
// reciprocals used for every division by a constant in the datapath.
// ----------------------------------------------------------------------------
package ucal_pkg;

    // Number of register stages from input to result register.
    localparam int Stages = 9;

    typedef logic [Stages-1:0] stage_en_t;

    // Day count shift so that day zero is 0000-03-01, and era boundaries.
    localparam logic [19:0] DaysShift  = 20'd719468;
    localparam logic [19:0] Era4Start  = 20'd584388;
    localparam logic [19:0] Era5Start  = 20'd730485;
    localparam logic [17:0] EraLastDay = 18'd146096;

    // Reciprocals rounded up: for an n-bit dividend and a divisor below 2^m,
    // floor(x / d) equals (x * ceil(2^(n+m) / d)) >> (n+m) for every x.
    localparam logic [25:0] Recip675   = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
    localparam logic [13:0] Recip225   = 14'(((64'd1 << 21) + 64'd224) / 64'd225);
    localparam logic [10:0] Recip15    = 11'(((64'd1 << 14) + 64'd14) / 64'd15);
    localparam logic [16:0] Recip7     = 17'(((64'd1 << 19) + 64'd6) / 64'd7);
    localparam logic [18:0] Recip1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] Recip36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] Recip365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  Recip100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] Recip153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    // Day of the March-based year on which each month starts.
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] res;
        case (mp)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd31;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd92;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd184;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd245;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd337;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/ucal_day_split.sv =====
// ----------------------------------------------------------------------------
// Unix seconds to calendar: day split
// Stages 0 and 1: splits seconds into day count and second of day, then the
// shifted day count into era and day of era, and starts the weekday division.
// ----------------------------------------------------------------------------
module ucal_day_split
(
    input  logic                clk,
    input  ucal_pkg::stage_en_t en,
    input  logic [31:0]         unix_seconds,
    output logic [16:0]         sod,
    output logic [17:0]         doe,
    output logic                era5,
    output logic [15:0]         days3,
    output logic [12:0]         wq
);

    // Stage 0: days = seconds / 86400, done as (seconds >> 7) / 675.
    logic [50:0] days_prod;
    logic [31:0] s0_secs_reg;
    logic [15:0] s0_days_reg;

    assign days_prod = 51'(unix_seconds[31:7]) * 51'(ucal_pkg::Recip675);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_secs_reg <= unix_seconds;
            s0_days_reg <= days_prod[50:35];
        end
    end

    // Stage 1: second of day, era and day of era, weekday quotient.
    logic [24:0] days675;
    logic [24:0] rem675;
    logic [19:0] z;
    logic        era5_next;
    logic [19:0] doe_wide;
    logic [15:0] days3_next;
    logic [32:0] wq_prod;

    logic [16:0] s1_sod_reg;
    logic [17:0] s1_doe_reg;
    logic        s1_era5_reg;
    logic [15:0] s1_days3_reg;
    logic [12:0] s1_wq_reg;

    always_comb
    begin
        days675    = 25'(s0_days_reg) * 25'd675;
        rem675     = s0_secs_reg[31:7] - days675;
        z          = 20'(s0_days_reg) + ucal_pkg::DaysShift;
        era5_next  = (z >= ucal_pkg::Era5Start);
        doe_wide   = z - (era5_next ? ucal_pkg::Era5Start : ucal_pkg::Era4Start);
        days3_next = s0_days_reg + 16'd3;
        wq_prod    = 33'(days3_next) * 33'(ucal_pkg::Recip7);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_sod_reg   <= {rem675[9:0], s0_secs_reg[6:0]};
            s1_doe_reg   <= doe_wide[17:0];
            s1_era5_reg  <= era5_next;
            s1_days3_reg <= days3_next;
            s1_wq_reg    <= wq_prod[31:19];
        end
    end

    assign sod   = s1_sod_reg;
    assign doe   = s1_doe_reg;
    assign era5  = s1_era5_reg;
    assign days3 = s1_days3_reg;
    assign wq    = s1_wq_reg;

endmodule

// ===== hw/rtl/ucal_tod.sv =====
// ----------------------------------------------------------------------------
// Unix seconds to calendar: time of day
// Stages 2 to 8: hours, minutes and seconds from the second of the day,
// then delayed to line up with the date path.
// ----------------------------------------------------------------------------
module ucal_tod
(
    input  logic                clk,
    input  ucal_pkg::stage_en_t en,
    input  logic [16:0]         sod,
    output logic [4:0]          hours,
    output logic [5:0]          minutes,
    output logic [5:0]          seconds
);

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } tod_t;

    // Stage 2: hours = (sod >> 4) / 225.
    logic [26:0] h_prod;
    logic [16:0] s2_sod_reg;
    logic [4:0]  s2_hours_reg;

    assign h_prod = 27'(sod[16:4]) * 27'(ucal_pkg::Recip225);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_sod_reg   <= sod;
            s2_hours_reg <= h_prod[25:21];
        end
    end

    // Stage 3: second of the hour.
    logic [16:0] h3600;
    logic [16:0] remh_wide;
    logic [4:0]  s3_hours_reg;
    logic [11:0] s3_remh_reg;

    assign h3600     = 17'(s2_hours_reg) * 17'd3600;
    assign remh_wide = s2_sod_reg - h3600;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_hours_reg <= s2_hours_reg;
            s3_remh_reg  <= remh_wide[11:0];
        end
    end

    // Stage 4: minutes = (remh >> 2) / 15.
    logic [20:0] m_prod;
    logic [4:0]  s4_hours_reg;
    logic [11:0] s4_remh_reg;
    logic [5:0]  s4_min_reg;

    assign m_prod = 21'(s3_remh_reg[11:2]) * 21'(ucal_pkg::Recip15);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_hours_reg <= s3_hours_reg;
            s4_remh_reg  <= s3_remh_reg;
            s4_min_reg   <= m_prod[19:14];
        end
    end

    // Stage 5: seconds, then stages 6 to 8 carry the result along.
    logic [11:0] m60;
    logic [11:0] sec_wide;
    tod_t        tod_next;
    tod_t        tod_reg [5:ucal_pkg::Stages-1];

    always_comb
    begin
        m60              = 12'(s4_min_reg) * 12'd60;
        sec_wide         = s4_remh_reg - m60;
        tod_next.hours   = s4_hours_reg;
        tod_next.minutes = s4_min_reg;
        tod_next.seconds = sec_wide[5:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            tod_reg[5] <= tod_next;
        end
        for (int k = 6; k < ucal_pkg::Stages; k++)
        begin
            if (en[k])
            begin
                tod_reg[k] <= tod_reg[k-1];
            end
        end
    end

    assign hours   = tod_reg[ucal_pkg::Stages-1].hours;
    assign minutes = tod_reg[ucal_pkg::Stages-1].minutes;
    assign seconds = tod_reg[ucal_pkg::Stages-1].seconds;

endmodule

// ===== hw/rtl/ucal_date.sv =====
// ----------------------------------------------------------------------------
// Unix seconds to calendar: civil date
// Stages 2 to 8: year of era, day of year, month and day of month from the
// day of era, plus the weekday remainder.
// ----------------------------------------------------------------------------
module ucal_date
(
    input  logic                clk,
    input  ucal_pkg::stage_en_t en,
    input  logic [17:0]         doe,
    input  logic                era5,
    input  logic [15:0]         days3,
    input  logic [12:0]         wq,
    output logic [11:0]         year,
    output logic [3:0]          month,
    output logic [4:0]          day,
    output logic [2:0]          weekday
);

    // Stage 2: leap corrections doe / 1460, doe / 36524, last day of era, and the weekday.
    logic [36:0] a_prod;
    logic [36:0] b_prod;
    logic [15:0] wq7;
    logic [15:0] wrem;

    logic [17:0] s2_doe_reg;
    logic        s2_era5_reg;
    logic [6:0]  s2_a_reg;
    logic [2:0]  s2_b_reg;
    logic        s2_c_reg;
    logic [2:0]  s2_wd_reg;

    always_comb
    begin
        a_prod = 37'(doe) * 37'(ucal_pkg::Recip1460);
        b_prod = 37'(doe) * 37'(ucal_pkg::Recip36524);
        wq7    = 16'(wq) * 16'd7;
        wrem   = days3 - wq7;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_doe_reg  <= doe;
            s2_era5_reg <= era5;
            s2_a_reg    <= a_prod[35:29];
            s2_b_reg    <= b_prod[36:34];
            s2_c_reg    <= (doe == ucal_pkg::EraLastDay);
            s2_wd_reg   <= wrem[2:0] + 3'd1;
        end
    end

    // Stage 3: day of era with leap days taken out.
    logic [17:0] s3_doe_reg;
    logic        s3_era5_reg;
    logic [17:0] s3_t_reg;
    logic [2:0]  s3_wd_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_doe_reg  <= s2_doe_reg;
            s3_era5_reg <= s2_era5_reg;
            s3_t_reg    <= s2_doe_reg - 18'(s2_a_reg) + 18'(s2_b_reg) - 18'(s2_c_reg);
            s3_wd_reg   <= s2_wd_reg;
        end
    end

    // Stage 4: year of era = t / 365.
    logic [36:0] y_prod;
    logic [17:0] s4_doe_reg;
    logic        s4_era5_reg;
    logic [8:0]  s4_yoe_reg;
    logic [2:0]  s4_wd_reg;

    assign y_prod = 37'(s3_t_reg) * 37'(ucal_pkg::Recip365);

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_doe_reg  <= s3_doe_reg;
            s4_era5_reg <= s3_era5_reg;
            s4_yoe_reg  <= y_prod[35:27];
            s4_wd_reg   <= s3_wd_reg;
        end
    end

    // Stage 5: days before this year of era, without the century term.
    logic [18:0] q_prod;
    logic [17:0] s5_doe_reg;
    logic        s5_era5_reg;
    logic [8:0]  s5_yoe_reg;
    logic [17:0] s5_y365_reg;
    logic [1:0]  s5_q100_reg;
    logic [2:0]  s5_wd_reg;

    assign q_prod = 19'(s4_yoe_reg) * 19'(ucal_pkg::Recip100);

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_doe_reg  <= s4_doe_reg;
            s5_era5_reg <= s4_era5_reg;
            s5_yoe_reg  <= s4_yoe_reg;
            s5_y365_reg <= 18'(s4_yoe_reg) * 18'd365 + 18'(s4_yoe_reg[8:2]);
            s5_q100_reg <= q_prod[17:16];
            s5_wd_reg   <= s4_wd_reg;
        end
    end

    // Stage 6: day of the March-based year.
    logic [17:0] doy_wide;
    logic [8:0]  s6_doy_reg;
    logic        s6_era5_reg;
    logic [8:0]  s6_yoe_reg;
    logic [2:0]  s6_wd_reg;

    assign doy_wide = s5_doe_reg - (s5_y365_reg - 18'(s5_q100_reg));

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_doy_reg  <= doy_wide[8:0];
            s6_era5_reg <= s5_era5_reg;
            s6_yoe_reg  <= s5_yoe_reg;
            s6_wd_reg   <= s5_wd_reg;
        end
    end

    // Stage 7: March-based month = (5 * doy + 2) / 153.
    logic [10:0] mp_num;
    logic [22:0] mp_prod;
    logic [8:0]  s7_doy_reg;
    logic [3:0]  s7_mp_reg;
    logic        s7_era5_reg;
    logic [8:0]  s7_yoe_reg;
    logic [2:0]  s7_wd_reg;

    always_comb
    begin
        mp_num  = {s6_doy_reg, 2'b00} + 11'(s6_doy_reg) + 11'd2;
        mp_prod = 23'(mp_num) * 23'(ucal_pkg::Recip153);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_doy_reg  <= s6_doy_reg;
            s7_mp_reg   <= mp_prod[22:19];
            s7_era5_reg <= s6_era5_reg;
            s7_yoe_reg  <= s6_yoe_reg;
            s7_wd_reg   <= s6_wd_reg;
        end
    end

    // Stage 8: calendar fields. January and February belong to the next year.
    logic [8:0]  dom_wide;
    logic        jan_feb;
    logic [11:0] year_next;
    logic [3:0]  month_next;

    logic [11:0] s8_year_reg;
    logic [3:0]  s8_month_reg;
    logic [4:0]  s8_day_reg;
    logic [2:0]  s8_wd_reg;

    always_comb
    begin
        jan_feb    = (s7_mp_reg >= 4'd10);
        dom_wide   = s7_doy_reg - ucal_pkg::month_start(s7_mp_reg) + 9'd1;
        month_next = jan_feb ? (s7_mp_reg - 4'd9) : (s7_mp_reg + 4'd3);
        year_next  = 12'(s7_yoe_reg) + (s7_era5_reg ? 12'd2000 : 12'd1600)
                     + 12'(jan_feb);
    end

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_year_reg  <= year_next;
            s8_month_reg <= month_next;
            s8_day_reg   <= dom_wide[4:0];
            s8_wd_reg    <= s7_wd_reg;
        end
    end

    assign year    = s8_year_reg;
    assign month   = s8_month_reg;
    assign day     = s8_day_reg;
    assign weekday = s8_wd_reg;

endmodule

// ===== hw/rtl/unix_seconds_to_calendar.sv =====
// ----------------------------------------------------------------------------
// Unix seconds to calendar: top level
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00
// into Gregorian year, month, day, weekday and time of day.
// ----------------------------------------------------------------------------
// Usage. The input channel (in_valid, in_ready, unix_seconds) takes one
// timestamp per transfer; the output channel (out_valid, out_ready and the
// seven calendar fields) gives exactly one result per timestamp, in order.
// Every 32-bit value is a valid timestamp; the latest falls in 2106.
// The nine register stages hold at most one constant multiplication on
// any path through a stage. When the receiver does not stall, throughput
// is one transfer per cycle on both channels.
// Reset clears every stage valid bit, so the pipeline comes up empty with
// in_ready high and out_valid low; the datapath registers are not reset.
// When the receiver stalls, the result register holds its item and each
// stage holds only while the stage after it is full, so empty slots close up
// and in_ready falls only once all nine stages hold items. No transfer is
// lost or repeated.
// ----------------------------------------------------------------------------
module unix_seconds_to_calendar
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] unix_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [2:0]  weekday,
    output logic [4:0]  hours,
    output logic [5:0]  minutes,
    output logic [5:0]  seconds
);

    // One valid bit per stage travels alongside the data.
    ucal_pkg::stage_en_t valid_reg;
    ucal_pkg::stage_en_t valid_next;
    ucal_pkg::stage_en_t stage_en;

    // A stage may load when it is empty or when the stage after it moves on.
    // The last stage looks at the receiver's ready.
    always_comb
    begin
        stage_en[ucal_pkg::Stages-1] = !valid_reg[ucal_pkg::Stages-1] || out_ready;
        for (int k = ucal_pkg::Stages - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (stage_en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < ucal_pkg::Stages; k++)
        begin
            if (stage_en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_en[0];
    assign out_valid = valid_reg[ucal_pkg::Stages-1];

    // Datapath: the day split feeds the time-of-day and date paths, which
    // both end in the result register at the last stage.
    logic [16:0] sod;
    logic [17:0] doe;
    logic        era5;
    logic [15:0] days3;
    logic [12:0] wq;

    ucal_day_split u_day_split
    (
        .clk          (clk),
        .en           (stage_en),
        .unix_seconds (unix_seconds),
        .sod          (sod),
        .doe          (doe),
        .era5         (era5),
        .days3        (days3),
        .wq           (wq)
    );

    ucal_tod u_tod
    (
        .clk     (clk),
        .en      (stage_en),
        .sod     (sod),
        .hours   (hours),
        .minutes (minutes),
        .seconds (seconds)
    );

    ucal_date u_date
    (
        .clk     (clk),
        .en      (stage_en),
        .doe     (doe),
        .era5    (era5),
        .days3   (days3),
        .wq      (wq),
        .year    (year),
        .month   (month),
        .day     (day),
        .weekday (weekday)
    );

    // With the result register empty, the ready chain must let a new
    // transfer in.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("in_ready low while the output stage is empty");

    // Every delivered date lies in the calendar.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (year >= 12'd1970) && (year <= 12'd2106)
                      && (month >= 4'd1) && (month <= 4'd12)
                      && (day >= 5'd1) && (day <= 5'd31)
                      && (weekday >= 3'd1) && (weekday <= 3'd7))
    else $error("date field out of range");

    // February never has more than 29 days.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (month == 4'd2) |-> (day <= 5'd29))
    else $error("February day out of range");

    // Time-of-day fields stay within a day.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hours <= 5'd23) && (minutes <= 6'd59) && (seconds <= 6'd59))
    else $error("time of day out of range");

endmodule
